>>> rtl/lzwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwf_pkg
// Types, constants and helpers shared by the fixed-width LZW encoder.
// ----------------------------------------------------------------------------
package lzwf_pkg;

	localparam int CODE_BITS = 12;
	localparam int CW        = CODE_BITS;
	localparam int NW        = CODE_BITS + 1;
	localparam int HB        = CODE_BITS + 1;
	localparam int OUT_W     = 12;
	localparam int H_DEPTH   = 1 << HB;
	localparam int D_DEPTH   = 1 << CW;
	localparam int FQ_AW     = 1;
	localparam int FQ_DEPTH  = 1 << FQ_AW;

	localparam logic [CW-1:0] CLEAR_MARK  = CW'(256);
	localparam logic [CW-1:0] FIRST_FREE  = CW'(257);
	localparam logic [NW-1:0] FIRST_FREE_N = NW'(257);
	localparam logic [NW-1:0] TABLE_FULL  = NW'(D_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HREAD,
		ST_DREAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CW-1:0] parent;
		logic [7:0]    sym;
		logic [HB-1:0] slot;
	} dict_ent_t;

	typedef struct packed {
		logic            h_rd_en;
		logic [HB-1:0]   h_rd_addr;
		logic            h_wr_en;
		logic [HB-1:0]   h_wr_addr;
		logic [CW-1:0]   h_wr_data;
		logic            d_rd_en;
		logic [CW-1:0]   d_rd_addr;
		logic            d_wr_en;
		logic [CW-1:0]   d_wr_addr;
		dict_ent_t       d_wr_data;
	} dict_req_t;

	typedef struct packed {
		logic [CW-1:0] h_rd_data;
		dict_ent_t     d_rd_data;
	} dict_rsp_t;

	typedef struct packed {
		logic [OUT_W-1:0] code;
		logic             last;
		logic             eos;
	} result_t;

	function automatic logic [HB-1:0] lzwf_hash(input logic [CW-1:0] p, input logic [7:0] b);
		return {1'b0, p} ^ {b, {(HB-8){1'b0}}};
	endfunction

	function automatic logic [CW-1:0] lzwf_lit(input logic [7:0] b);
		return {{(CW-8){1'b0}}, b};
	endfunction

	function automatic logic [OUT_W-1:0] lzwf_out(input logic [CW-1:0] c);
		logic [CW+OUT_W-1:0] ext;
		ext = {{OUT_W{1'b0}}, c};
		return ext[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/lzwf_dict.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwf_dict
// Hash slot memory (slot -> code) and entry memory (code -> parent, symbol,
// slot). Both synchronous, with registered read data.
// ----------------------------------------------------------------------------
module lzwf_dict
	import lzwf_pkg::*;
(
	input  wire       clk,
	input  dict_req_t req,
	output dict_rsp_t rsp
);

	logic [CW-1:0] h_mem [H_DEPTH];
	dict_ent_t     d_mem [D_DEPTH];
	logic [CW-1:0] h_rd_q;
	dict_ent_t     d_rd_q;

	always_ff @(posedge clk) begin
		if (req.h_wr_en) begin
			h_mem[req.h_wr_addr] <= req.h_wr_data;
		end
		if (req.h_rd_en) begin
			h_rd_q <= h_mem[req.h_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.d_wr_en) begin
			d_mem[req.d_wr_addr] <= req.d_wr_data;
		end
		if (req.d_rd_en) begin
			d_rd_q <= d_mem[req.d_rd_addr];
		end
	end

	assign rsp.h_rd_data = h_rd_q;
	assign rsp.d_rd_data = d_rd_q;

endmodule
`default_nettype wire

>>> rtl/lzwf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwf_out_fifo
// Small result queue; its head register drives the output channel.
// ----------------------------------------------------------------------------
module lzwf_out_fifo
	import lzwf_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     push,
	input  result_t push_data,
	output logic    full,
	output logic    head_valid,
	input  wire     pop,
	output result_t head
);

	result_t          mem [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == (FQ_AW+1)'(FQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lzw_fixed_width_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_fixed_width_encoder_unit
// LZW encoder with fixed-width codes: one byte a beat in, codes out.
// ----------------------------------------------------------------------------
// channel   direction  handshake                payload
// data      in         data_valid / data_stall  data_byte, end_of_data
// code      out        code_valid / code_stall  code, last_in_run, end_of_stream
//
// the first byte of a stream only sets the prefix, or is flushed if it ends
// the stream. other bytes take a hash slot read and an entry read, plus another
// of each per extra probe on a slot collision; each emitted code then goes into
// the output queue. after reset all 2^(CODE_BITS+1) = 8192 hash slots are
// swept, with data_stall high. code_stall holds the 2-entry output queue; the
// emit step waits only while that queue is full, and queued codes stay put.
// ----------------------------------------------------------------------------
module lzw_fixed_width_encoder_unit
	import lzwf_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              data_valid,
	output logic             data_stall,
	input  wire  [7:0]       data_byte,
	input  wire              end_of_data,
	output logic             code_valid,
	input  wire              code_stall,
	output logic [OUT_W-1:0] code,
	output logic             last_in_run,
	output logic             end_of_stream
);

	state_t        state_q;
	state_t        state_d;
	logic [HB-1:0] clr_q;
	logic [CW-1:0] prefix_q;
	logic          pvalid_q;
	logic [NW-1:0] nf_q;
	logic [2:0]    pend_q;
	logic [7:0]    byte_q;
	logic          end_q;
	logic [HB-1:0] slot_q;
	logic [CW-1:0] cand_q;
	logic [CW-1:0] pcode_q [3];

	dict_req_t     req;
	dict_rsp_t     rsp;
	dict_ent_t     dent;
	result_t       push_data;
	result_t       head;
	logic          fifo_full;
	logic          push;

	logic          accept;
	logic [HB-1:0] hash_slot;
	logic          ent_ok;
	logic          hit;
	logic          probe_on;
	logic [NW-1:0] nf_inc;
	logic          table_full;
	logic [CW-1:0] new_prefix;
	logic [1:0]    sel;
	logic [2:0]    pend_left;
	logic          sel_last;

	assign data_stall = (state_q != ST_IDLE);
	assign accept     = data_valid && !data_stall;
	assign hash_slot  = lzwf_hash(prefix_q, data_byte);
	assign dent       = rsp.d_rd_data;
	assign ent_ok     = (cand_q >= FIRST_FREE) && ({1'b0, cand_q} < nf_q) &&
	                    (dent.slot == slot_q);
	assign hit        = ent_ok && (dent.parent == prefix_q) && (dent.sym == byte_q);
	assign probe_on   = ent_ok && !hit;
	assign nf_inc     = nf_q + 1'b1;
	assign table_full = (nf_inc == TABLE_FULL);
	assign new_prefix = hit ? cand_q : lzwf_lit(byte_q);

	always_comb begin
		if (pend_q[0]) begin
			sel = 2'd0;
		end else if (pend_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
		pend_left      = pend_q;
		pend_left[sel] = 1'b0;
		sel_last       = (pend_left == 3'b000);
	end

	assign push           = (state_q == ST_EMIT) && !fifo_full;
	assign push_data.code = lzwf_out(pcode_q[sel]);
	assign push_data.last = sel_last;
	assign push_data.eos  = (sel == 2'd2);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {HB{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (pvalid_q) begin
						state_d = ST_HREAD;
					end else if (end_of_data) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_HREAD: state_d = ST_DREAD;
			ST_DREAD: begin
				if (probe_on) begin
					state_d = ST_HREAD;
				end else if (!hit || end_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (push && sel_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory requests
	always_comb begin
		req           = '0;
		req.h_rd_addr = hash_slot;
		req.h_wr_addr = slot_q;
		req.h_wr_data = nf_q[CW-1:0];
		req.d_rd_addr = rsp.h_rd_data;
		req.d_wr_addr = nf_q[CW-1:0];
		req.d_wr_data = '{parent: prefix_q, sym: byte_q, slot: slot_q};
		case (state_q)
			ST_CLEAR: begin
				req.h_wr_en   = 1'b1;
				req.h_wr_addr = clr_q;
				req.h_wr_data = '0;
			end
			ST_IDLE: begin
				req.h_rd_en = accept && pvalid_q;
			end
			ST_HREAD: begin
				req.d_rd_en = 1'b1;
			end
			ST_DREAD: begin
				if (probe_on) begin
					req.h_rd_en   = 1'b1;
					req.h_rd_addr = slot_q + 1'b1;
				end else if (!hit) begin
					req.h_wr_en = 1'b1;
					req.d_wr_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			prefix_q <= '0;
			pvalid_q <= 1'b0;
			nf_q     <= FIRST_FREE_N;
			pend_q   <= 3'b000;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept && !pvalid_q) begin
						if (end_of_data) begin
							pend_q <= 3'b100;
						end else begin
							prefix_q <= lzwf_lit(data_byte);
							pvalid_q <= 1'b1;
						end
					end
				end
				ST_DREAD: begin
					if (!probe_on) begin
						pend_q <= {end_q, !hit && table_full, !hit};
						if (end_q) begin
							prefix_q <= '0;
							pvalid_q <= 1'b0;
							nf_q     <= FIRST_FREE_N;
						end else begin
							prefix_q <= new_prefix;
							if (!hit) begin
								nf_q <= table_full ? FIRST_FREE_N : nf_inc;
							end
						end
					end
				end
				ST_EMIT: begin
					if (push) begin
						pend_q <= pend_left;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					byte_q     <= data_byte;
					end_q      <= end_of_data;
					slot_q     <= hash_slot;
					pcode_q[2] <= lzwf_lit(data_byte);
				end
			end
			ST_HREAD: begin
				cand_q <= rsp.h_rd_data;
			end
			ST_DREAD: begin
				if (probe_on) begin
					slot_q <= slot_q + 1'b1;
				end else begin
					pcode_q[0] <= prefix_q;
					pcode_q[1] <= CLEAR_MARK;
					pcode_q[2] <= new_prefix;
				end
			end
			default: begin
			end
		endcase
	end

	lzwf_dict u_dict (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	lzwf_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (fifo_full),
		.head_valid (code_valid),
		.pop        (!code_stall),
		.head       (head)
	);

	assign code          = head.code;
	assign last_in_run   = head.last;
	assign end_of_stream = head.eos;

endmodule
`default_nettype wire

>>> rtl/lzwf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwf_checker
// Port-level checks for the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzwf_checker
	import lzwf_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             data_valid,
	input wire             data_stall,
	input wire [7:0]       data_byte,
	input wire             end_of_data,
	input wire             code_valid,
	input wire             code_stall,
	input wire [OUT_W-1:0] code,
	input wire             last_in_run,
	input wire             end_of_stream
);

	// a held result beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && code_stall |=> code_valid && $stable(code) &&
		$stable(last_in_run) && $stable(end_of_stream))
		else $error("stalled result beat changed");

	// the flushed code always closes its run
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && end_of_stream |-> last_in_run)
		else $error("end of stream without last in run");

	// a final byte always leaves a flush to emit
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_stall && end_of_data |=> data_stall)
		else $error("final byte taken without flush");

endmodule

bind lzw_fixed_width_encoder_unit lzwf_checker u_lzwf_checker (.*);
`default_nettype wire

>>> test/lzw_fixed_width_encoder_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_fixed_width_encoder_unit_checker
// Watches both channels of the encoder, keeps its own LZW dictionary and
// prefix, predicts the codes each accepted byte causes and compares them in
// order with the codes the block hands out.
// ----------------------------------------------------------------------------
module lzw_fixed_width_encoder_unit_checker
	import lzwf_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire              data_valid,
	input  wire              data_stall,
	input  wire  [7:0]       data_byte,
	input  wire              end_of_data,
	input  wire              code_valid,
	input  wire              code_stall,
	input  wire  [OUT_W-1:0] code,
	input  wire              last_in_run,
	input  wire              end_of_stream,
	output int               fail_count,
	output int               pending_count,
	output int               checked_count,
	output int               hit_count,
	output int               marker_count
);

	logic [CW-1:0] pair_table [logic [CW+7:0]];
	logic [CW-1:0] run_prefix;
	logic          run_open;
	logic [NW-1:0] free_code;
	result_t       expected_codes [$];

	initial begin
		fail_count    = 0;
		pending_count = 0;
		checked_count = 0;
		hit_count     = 0;
		marker_count  = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic restart_stream();
		pair_table.delete();
		run_prefix = '0;
		run_open   = 1'b0;
		free_code  = FIRST_FREE_N;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic e);
		result_t       step_codes [$];
		result_t       r;
		logic [CW+7:0] key;
		key = {run_prefix, b};
		if (!run_open) begin
			run_prefix = CW'(b);
			run_open   = 1'b1;
		end else if (pair_table.exists(key)) begin
			run_prefix = pair_table[key];
			hit_count++;
		end else begin
			r = '{code: OUT_W'(run_prefix), last: 1'b0, eos: 1'b0};
			step_codes = {step_codes, r};
			if (free_code < TABLE_FULL) begin
				pair_table[key] = free_code[CW-1:0];
				free_code++;
			end
			if (free_code >= TABLE_FULL) begin
				r = '{code: OUT_W'(CLEAR_MARK), last: 1'b0, eos: 1'b0};
				step_codes = {step_codes, r};
				pair_table.delete();
				free_code = FIRST_FREE_N;
				marker_count++;
			end
			run_prefix = CW'(b);
		end
		if (e) begin
			r = '{code: OUT_W'(run_prefix), last: 1'b0, eos: 1'b1};
			step_codes = {step_codes, r};
			restart_stream();
		end
		if (step_codes.size() > 0)
			step_codes[step_codes.size()-1].last = 1'b1;
		expected_codes = {expected_codes, step_codes};
	endtask

	task automatic check_code();
		result_t want;
		if (expected_codes.size() == 0) begin
			report_mismatch($sformatf("code %0d arrived with nothing expected", code));
		end else begin
			want = expected_codes.pop_front();
			checked_count++;
			if (code !== want.code)
				report_mismatch($sformatf("code %0d, expected %0d", code, want.code));
			if (last_in_run !== want.last)
				report_mismatch($sformatf("last_in_run %b, expected %b on code %0d",
					last_in_run, want.last, want.code));
			if (end_of_stream !== want.eos)
				report_mismatch($sformatf("end_of_stream %b, expected %b on code %0d",
					end_of_stream, want.eos, want.code));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_stream();
			expected_codes.delete();
		end else begin
			if (data_valid && !data_stall)
				predict_byte(data_byte, end_of_data);
			if (code_valid && !code_stall)
				check_code();
		end
		pending_count = expected_codes.size();
	end

endmodule

>>> test/lzw_fixed_width_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_fixed_width_encoder_unit_tb
// Drives byte streams into the LZW encoder: short directed streams with no
// gaps, then random streams with random gaps and a long hold on the code
// side. The checker predicts and compares the codes.
// ----------------------------------------------------------------------------
module lzw_fixed_width_encoder_unit_tb;
	import lzwf_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             data_valid;
	logic             data_stall;
	logic [7:0]       data_byte;
	logic             end_of_data;
	logic             code_valid;
	logic             code_stall;
	logic [OUT_W-1:0] code;
	logic             last_in_run;
	logic             end_of_stream;

	int fail_count;
	int pending_count;
	int checked_count;
	int hit_count;
	int marker_count;

	bit no_idle;
	bit pressure_go;
	bit pressure_done;
	int byte_count;
	int stream_count;

	localparam int DIR_N = 22;
	logic [7:0] dir_bytes [DIR_N] = '{
		8'h00, 8'hff,
		8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'h00, 8'h55, 8'haa,
		8'h80, 8'h01, 8'h80, 8'h01
	};
	logic dir_eod [DIR_N] = '{
		1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1
	};

	lzw_fixed_width_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.end_of_data   (end_of_data),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.last_in_run   (last_in_run),
		.end_of_stream (end_of_stream)
	);

	lzw_fixed_width_encoder_unit_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_valid    (data_valid),
		.data_stall    (data_stall),
		.data_byte     (data_byte),
		.end_of_data   (end_of_data),
		.code_valid    (code_valid),
		.code_stall    (code_stall),
		.code          (code),
		.last_in_run   (last_in_run),
		.end_of_stream (end_of_stream),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.hit_count     (hit_count),
		.marker_count  (marker_count)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic send_beat(input logic [7:0] b, input logic e);
		while (!no_idle && $urandom_range(0, 99) < 36) begin
			data_valid <= 1'b0;
			@(negedge clk);
		end
		data_valid  <= 1'b1;
		data_byte   <= b;
		end_of_data <= e;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		byte_count++;
		if (e)
			stream_count++;
		@(negedge clk);
	endtask

	// code side: random stalls, one long hold once the random part starts
	initial begin
		code_stall    = 1'b0;
		pressure_done = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				code_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end
			code_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 36);
		end
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d codes still expected", pending_count);
		$display("[lzw_fixed_width_encoder_unit] ERROR");
		$finish;
	end

	initial begin
		int         sent;
		int         len;
		int         nsym;
		bit         wide;
		int         guard;
		logic [7:0] alpha [4];
		logic [7:0] b;
		data_valid   = 1'b0;
		data_byte    = '0;
		end_of_data  = 1'b0;
		arst_n       = 1'b0;
		no_idle      = 1'b0;
		pressure_go  = 1'b0;
		byte_count   = 0;
		stream_count = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed streams back to back, no gaps on either side
		no_idle = 1'b1;
		for (int i = 0; i < DIR_N; i++)
			send_beat(dir_bytes[i], dir_eod[i]);
		no_idle = 1'b0;

		pressure_go = 1'b1;
		sent = 0;
		while (sent < 86) begin
			len  = $urandom_range(1, 14);
			nsym = $urandom_range(1, 4);
			wide = ($urandom_range(0, 9) < 3);
			for (int k = 0; k < 4; k++)
				alpha[k] = 8'($urandom_range(0, 255));
			for (int i = 0; i < len; i++) begin
				b = wide ? 8'($urandom_range(0, 255)) :
					alpha[2'($urandom_range(0, nsym - 1))];
				send_beat(b, i == len - 1);
				sent++;
			end
		end
		data_valid <= 1'b0;

		guard = 0;
		while (pending_count != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (64) @(negedge clk);
		if (pending_count != 0)
			$display("%0d expected codes never arrived", pending_count);

		$display("covered %0d bytes in %0d streams, directed and random, with a long code hold",
			byte_count, stream_count);
		$display("%0d codes checked, %0d dictionary hits, %0d table resets",
			checked_count, hit_count, marker_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("[lzw_fixed_width_encoder_unit] OK");
		end else begin
			$display("[lzw_fixed_width_encoder_unit] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/lzwf_pkg.sv
rtl/lzwf_dict.sv
rtl/lzwf_out_fifo.sv
rtl/lzw_fixed_width_encoder_unit.sv
rtl/lzwf_checker.sv
test/lzw_fixed_width_encoder_unit_checker.sv
test/lzw_fixed_width_encoder_unit_tb.sv
